>>> rtl/core/segment_line_intersect_core_macros.svh
`ifndef SEGMENT_LINE_INTERSECT_CORE_MACROS_SVH
`define SEGMENT_LINE_INTERSECT_CORE_MACROS_SVH

// Same-cycle implication check.
`define SLI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check.
`define SLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/sli_pkg.sv
`default_nettype none
package sli_pkg;

    localparam int COORD_W   = 32;
    localparam int DMAG_W    = 66;
    localparam int QUO_W     = 32;
    localparam int DIV_STEPS = 32;
    localparam int IN_W      = 288;
    localparam int OUT_W     = 104;

    typedef enum logic [1:0] {
        HIT_NONE      = 2'd0,
        HIT_POINT     = 2'd1,
        HIT_COLLINEAR = 2'd2
    } kind_t;

    // Per-item sideband that rides along the whole pipeline.
    typedef struct packed {
        logic                       det_zero;
        logic                       det_neg;
        kind_t                      zkind;
        logic [DMAG_W-1:0]          dmag;
        logic signed [COORD_W-1:0]  h;
        logic signed [COORD_W-1:0]  minx;
        logic signed [COORD_W-1:0]  maxx;
        logic signed [COORD_W-1:0]  miny;
        logic signed [COORD_W-1:0]  maxy;
    } side_t;

    // One division lane: partial remainder and numerator/quotient shift word.
    typedef struct packed {
        logic              neg;
        logic              ovf;
        logic [DMAG_W-1:0] rem;
        logic [QUO_W-1:0]  lq;
    } lane_t;

    typedef struct packed {
        kind_t                      kind;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
    } res_t;

endpackage
`default_nettype wire

>>> rtl/core/sli_front.sv
`default_nettype none
module sli_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [sli_pkg::IN_W-1:0] in_data,
    output logic                     out_valid,
    output sli_pkg::side_t           out_side,
    output sli_pkg::lane_t           out_x,
    output sli_pkg::lane_t           out_y
);
    import sli_pkg::*;

    logic signed [31:0] ax0, ay0, ax1, ay1, hgt, bx0, by0, bx1, by1;
    assign ax0 = in_data[31:0];
    assign ay0 = in_data[63:32];
    assign ax1 = in_data[95:64];
    assign ay1 = in_data[127:96];
    assign hgt = in_data[159:128];
    assign bx0 = in_data[191:160];
    assign by0 = in_data[223:192];
    assign bx1 = in_data[255:224];
    assign by1 = in_data[287:256];

    logic [7:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[6:0], in_valid};
        end
    end
    assign out_valid = vld_reg[7];

    // stage 1: differences and bounding box
    logic signed [32:0] dax_reg, day_reg, dbx_reg, dby_reg, ex_reg, ey_reg;
    logic signed [31:0] ax0_1_reg, ay0_1_reg;
    side_t side1_reg, side1_next;

    always_comb begin
        side1_next      = '0;
        side1_next.h    = hgt;
        side1_next.minx = (ax0 < ax1) ? ax0 : ax1;
        side1_next.maxx = (ax0 < ax1) ? ax1 : ax0;
        side1_next.miny = (ay0 < ay1) ? ay0 : ay1;
        side1_next.maxy = (ay0 < ay1) ? ay1 : ay0;
    end

    // stage 2: cross products
    logic signed [65:0] p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg;
    logic signed [32:0] dax2_reg, day2_reg;
    logic signed [31:0] ax0_2_reg, ay0_2_reg;
    logic dby0_2_reg, dbx0_2_reg, ex0_2_reg, ey0_2_reg, da0_2_reg;
    side_t side2_reg;

    // stage 3: determinant and numerator
    logic signed [66:0] det_reg, num_reg;
    logic coll_reg, dby0_3_reg, dbx0_3_reg, ex0_3_reg, ey0_3_reg, da0_3_reg;
    logic signed [32:0] dax3_reg, day3_reg;
    logic signed [31:0] ax0_3_reg, ay0_3_reg;
    side_t side3_reg;

    // stage 4: degenerate classification and split partial products
    side_t side4_reg, side4_next;
    logic signed [66:0] det_abs;
    logic signed [67:0] mxh_reg, mxl_reg, nxh_reg, nxl_reg;
    logic signed [67:0] myh_reg, myl_reg, nyh_reg, nyl_reg;

    always_comb begin
        det_abs             = det_reg[66] ? -det_reg : det_reg;
        side4_next          = side3_reg;
        side4_next.det_zero = (det_reg == '0);
        side4_next.det_neg  = det_reg[66];
        side4_next.dmag     = det_abs[65:0];
        priority if (dby0_3_reg) begin
            side4_next.zkind = ey0_3_reg ? HIT_COLLINEAR : HIT_NONE;
        end else if (dbx0_3_reg) begin
            side4_next.zkind = ex0_3_reg ? HIT_COLLINEAR : HIT_NONE;
        end else if (da0_3_reg) begin
            side4_next.zkind = HIT_NONE;
        end else begin
            side4_next.zkind = coll_reg ? HIT_COLLINEAR : HIT_NONE;
        end
    end

    // stage 5 and 6: recombine partial products, then sum
    logic signed [100:0] xa_reg, xb_reg, ya_reg, yb_reg, xn_reg, yn_reg;
    side_t side5_reg, side6_reg;

    // stage 7: magnitudes
    logic signed [100:0] xn_abs, yn_abs;
    logic [99:0] magx_reg, magy_reg;
    logic negx_reg, negy_reg;
    side_t side7_reg;

    assign xn_abs = xn_reg[100] ? -xn_reg : xn_reg;
    assign yn_abs = yn_reg[100] ? -yn_reg : yn_reg;

    // stage 8: range precheck and divider load
    lane_t lx_reg, ly_reg;
    side_t side8_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dax_reg   <= {ax1[31], ax1} - {ax0[31], ax0};
            day_reg   <= {ay1[31], ay1} - {ay0[31], ay0};
            dbx_reg   <= {bx1[31], bx1} - {bx0[31], bx0};
            dby_reg   <= {by1[31], by1} - {by0[31], by0};
            ex_reg    <= {bx0[31], bx0} - {ax0[31], ax0};
            ey_reg    <= {by0[31], by0} - {ay0[31], ay0};
            ax0_1_reg <= ax0;
            ay0_1_reg <= ay0;
            side1_reg <= side1_next;

            p1_reg     <= dax_reg * dby_reg;
            p2_reg     <= day_reg * dbx_reg;
            p3_reg     <= ex_reg * dby_reg;
            p4_reg     <= ey_reg * dbx_reg;
            p5_reg     <= ex_reg * day_reg;
            p6_reg     <= ey_reg * dax_reg;
            dby0_2_reg <= (dby_reg == '0);
            dbx0_2_reg <= (dbx_reg == '0);
            ex0_2_reg  <= (ex_reg == '0);
            ey0_2_reg  <= (ey_reg == '0);
            da0_2_reg  <= (dax_reg == '0) && (day_reg == '0);
            dax2_reg   <= dax_reg;
            day2_reg   <= day_reg;
            ax0_2_reg  <= ax0_1_reg;
            ay0_2_reg  <= ay0_1_reg;
            side2_reg  <= side1_reg;

            det_reg    <= p1_reg - p2_reg;
            num_reg    <= p3_reg - p4_reg;
            coll_reg   <= (p5_reg == p6_reg);
            dby0_3_reg <= dby0_2_reg;
            dbx0_3_reg <= dbx0_2_reg;
            ex0_3_reg  <= ex0_2_reg;
            ey0_3_reg  <= ey0_2_reg;
            da0_3_reg  <= da0_2_reg;
            dax3_reg   <= dax2_reg;
            day3_reg   <= day2_reg;
            ax0_3_reg  <= ax0_2_reg;
            ay0_3_reg  <= ay0_2_reg;
            side3_reg  <= side2_reg;

            mxh_reg   <= ax0_3_reg * $signed(det_reg[66:34]);
            mxl_reg   <= ax0_3_reg * $signed({1'b0, det_reg[33:0]});
            nxh_reg   <= dax3_reg * $signed(num_reg[66:34]);
            nxl_reg   <= dax3_reg * $signed({1'b0, num_reg[33:0]});
            myh_reg   <= ay0_3_reg * $signed(det_reg[66:34]);
            myl_reg   <= ay0_3_reg * $signed({1'b0, det_reg[33:0]});
            nyh_reg   <= day3_reg * $signed(num_reg[66:34]);
            nyl_reg   <= day3_reg * $signed({1'b0, num_reg[33:0]});
            side4_reg <= side4_next;

            xa_reg    <= (mxh_reg <<< 34) + mxl_reg;
            xb_reg    <= (nxh_reg <<< 34) + nxl_reg;
            ya_reg    <= (myh_reg <<< 34) + myl_reg;
            yb_reg    <= (nyh_reg <<< 34) + nyl_reg;
            side5_reg <= side4_reg;

            xn_reg    <= xa_reg + xb_reg;
            yn_reg    <= ya_reg + yb_reg;
            side6_reg <= side5_reg;

            magx_reg  <= xn_abs[99:0];
            magy_reg  <= yn_abs[99:0];
            negx_reg  <= xn_reg[100] ^ side6_reg.det_neg;
            negy_reg  <= yn_reg[100] ^ side6_reg.det_neg;
            side7_reg <= side6_reg;

            // quotient must fit QUO_W bits, else the point is far outside the box
            lx_reg.neg <= negx_reg;
            lx_reg.ovf <= (magx_reg[99:32] >= {2'b00, side7_reg.dmag});
            lx_reg.rem <= magx_reg[97:32];
            lx_reg.lq  <= magx_reg[31:0];
            ly_reg.neg <= negy_reg;
            ly_reg.ovf <= (magy_reg[99:32] >= {2'b00, side7_reg.dmag});
            ly_reg.rem <= magy_reg[97:32];
            ly_reg.lq  <= magy_reg[31:0];
            side8_reg  <= side7_reg;
        end
    end

    assign out_side = side8_reg;
    assign out_x    = lx_reg;
    assign out_y    = ly_reg;

endmodule
`default_nettype wire

>>> rtl/core/sli_div_step.sv
`default_nettype none
module sli_div_step (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  sli_pkg::side_t in_side,
    input  sli_pkg::lane_t in_x,
    input  sli_pkg::lane_t in_y,
    output logic           out_valid,
    output sli_pkg::side_t out_side,
    output sli_pkg::lane_t out_x,
    output sli_pkg::lane_t out_y
);
    import sli_pkg::*;

    // one restoring step: shift in the next numerator bit, subtract if it fits
    function automatic lane_t div_bit(lane_t l, logic [DMAG_W-1:0] d);
        logic [DMAG_W:0] t;
        logic [DMAG_W:0] diff;
        lane_t r;
        t    = {l.rem, l.lq[QUO_W-1]};
        diff = t - {1'b0, d};
        r    = l;
        if (t >= {1'b0, d}) begin
            r.rem = diff[DMAG_W-1:0];
            r.lq  = {l.lq[QUO_W-2:0], 1'b1};
        end else begin
            r.rem = t[DMAG_W-1:0];
            r.lq  = {l.lq[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

    logic  valid_reg;
    side_t side_reg;
    lane_t x_reg, y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= in_side;
            x_reg    <= div_bit(in_x, in_side.dmag);
            y_reg    <= div_bit(in_y, in_side.dmag);
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;

endmodule
`default_nettype wire

>>> rtl/core/sli_back.sv
`default_nettype none
module sli_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  sli_pkg::side_t in_side,
    input  sli_pkg::lane_t in_x,
    input  sli_pkg::lane_t in_y,
    output logic           out_valid,
    output sli_pkg::res_t  out_res
);
    import sli_pkg::*;

    logic [2:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end
    assign out_valid = vld_reg[2];

    // round half away from zero on the magnitude
    logic        incx, incy;
    logic [32:0] qx_reg, qy_reg;
    logic        negx1_reg, negy1_reg, ovf1_reg;
    side_t       side1_reg;

    assign incx = ({in_x.rem, 1'b0} >= {1'b0, in_side.dmag});
    assign incy = ({in_y.rem, 1'b0} >= {1'b0, in_side.dmag});

    // apply sign
    logic signed [33:0] vx_reg, vy_reg;
    logic               ovf2_reg;
    side_t              side2_reg;

    // box test and result
    logic  in_box;
    res_t  res_reg, res_next;

    always_comb begin
        in_box = (vx_reg >= $signed({{2{side2_reg.minx[31]}}, side2_reg.minx}))
              && (vx_reg <= $signed({{2{side2_reg.maxx[31]}}, side2_reg.maxx}))
              && (vy_reg >= $signed({{2{side2_reg.miny[31]}}, side2_reg.miny}))
              && (vy_reg <= $signed({{2{side2_reg.maxy[31]}}, side2_reg.maxy}));
        res_next = '0;
        if (side2_reg.det_zero) begin
            res_next.kind = side2_reg.zkind;
        end else if (!ovf2_reg && in_box) begin
            res_next.kind = HIT_POINT;
            res_next.x    = vx_reg[31:0];
            res_next.y    = vy_reg[31:0];
            res_next.z    = side2_reg.h;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qx_reg    <= {1'b0, in_x.lq} + {32'd0, incx};
            qy_reg    <= {1'b0, in_y.lq} + {32'd0, incy};
            negx1_reg <= in_x.neg;
            negy1_reg <= in_y.neg;
            ovf1_reg  <= in_x.ovf | in_y.ovf;
            side1_reg <= in_side;

            vx_reg    <= negx1_reg ? -$signed({1'b0, qx_reg}) : $signed({1'b0, qx_reg});
            vy_reg    <= negy1_reg ? -$signed({1'b0, qy_reg}) : $signed({1'b0, qy_reg});
            ovf2_reg  <= ovf1_reg;
            side2_reg <= side1_reg;

            res_reg   <= res_next;
        end
    end

    assign out_res = res_reg;

endmodule
`default_nettype wire

>>> rtl/core/segment_line_intersect_core.sv
// Segment / line intersection core.
// Input stream (s_tvalid, s_tready, s_tdata): one transfer carries segment A
// (two endpoints and a height) and two points of line B, all signed Q16.16.
// Output stream (m_tvalid, m_tready, m_tdata): exactly one result per input,
// in order: hit kind (none/parallel, single point, collinear) and the point
// rounded to the Q16.16 grid, with A's height as z. Fields without a point are 0.
// Throughput: one transfer per cycle while the output is not stalled. The
// pipeline is 8 front stages (cross products, 67-bit determinant, split
// multiplies, magnitudes), a 32-stage restoring divider that resolves one
// quotient bit per stage for x and y, and 3 rounding/box stages.
// Reset (aresetn low, synchronous) empties every stage and the skid register.
// Stall: a skid register behind the output stage takes one result when the
// receiver holds m_tready low; while it is full, s_tready drops and the whole
// pipeline holds, so nothing is lost or repeated.
`default_nettype none
`include "segment_line_intersect_core_macros.svh"
module segment_line_intersect_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // seg_start_x, seg_start_y, seg_end_x, seg_end_y, seg_height,
    // line_start_x, line_start_y, line_end_x, line_end_y (32 bits each)
    input  logic [287:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit_kind[1:0], cross_x[33:2], cross_y[65:34], cross_z[97:66], zero pad
    output logic [103:0] m_tdata
);
    import sli_pkg::*;

    logic  en;
    logic  skid_valid_reg, skid_valid_next;
    res_t  skid_res_reg;

    // advance everything unless the skid register is occupied
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    logic  st_valid [DIV_STEPS+1];
    side_t st_side  [DIV_STEPS+1];
    lane_t st_x     [DIV_STEPS+1];
    lane_t st_y     [DIV_STEPS+1];

    sli_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .out_valid (st_valid[0]),
        .out_side  (st_side[0]),
        .out_x     (st_x[0]),
        .out_y     (st_y[0])
    );

    // divider chain, MSB of the quotient first
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        sli_div_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (st_valid[k]),
            .in_side   (st_side[k]),
            .in_x      (st_x[k]),
            .in_y      (st_y[k]),
            .out_valid (st_valid[k+1]),
            .out_side  (st_side[k+1]),
            .out_x     (st_x[k+1]),
            .out_y     (st_y[k+1])
        );
    end

    logic out_valid;
    res_t out_res;

    sli_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (st_valid[DIV_STEPS]),
        .in_side   (st_side[DIV_STEPS]),
        .in_x      (st_x[DIV_STEPS]),
        .in_y      (st_y[DIV_STEPS]),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    // Skid: capture the waiting result when the pipeline moves on under it;
    // drain it when the receiver takes the transfer.
    always_comb begin
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg) begin
            if (m_tready) begin
                skid_valid_next = 1'b0;
            end
        end else if (out_valid && !m_tready) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_valid_reg && out_valid && !m_tready) begin
            skid_res_reg <= out_res;
        end
    end

    res_t m_res;
    assign m_res    = skid_valid_reg ? skid_res_reg : out_res;
    assign m_tvalid = skid_valid_reg | out_valid;
    assign m_tdata  = {6'd0, m_res.z, m_res.y, m_res.x, m_res.kind};

    `SLI_ASSERT_NEXT(a_skid_holds, aclk, aresetn, aresetn && skid_valid_reg && !m_tready, skid_valid_reg, "skid dropped a waiting transfer")
    `SLI_ASSERT_NEXT(a_skid_fills, aclk, aresetn, aresetn && en && out_valid && !m_tready, skid_valid_reg, "stalled result not captured")
    `SLI_ASSERT_NEXT(a_hold_out, aclk, aresetn, aresetn && !en && out_valid, out_valid && $stable(out_res), "output stage moved during stall")
    `SLI_ASSERT_NOW(a_no_point_zero, aclk, aresetn, m_tvalid && (m_res.kind != HIT_POINT), (m_res.x == '0) && (m_res.y == '0) && (m_res.z == '0), "point fields set without a hit")

endmodule
`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import sli_pkg::*;

    localparam int WATCHDOG_CYCLES = 4000;
    localparam int DRAIN_CYCLES    = 60;
    localparam int RANDOM_ITEMS    = 1580;
    localparam int QUIET_ITEMS     = 200;

    // Expected-intersection store: computes the exact result for each accepted
    // transfer and compares outgoing transfers against it in order.
    class intersect_scoreboard;
        res_t expect_q[$];
        int   errors;

        function automatic res_t predict(logic [287:0] d);
            logic signed [127:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
            logic signed [127:0] dax, day, dbx, dby, det, num, xn, yn, lhs, rhs;
            logic signed [127:0] px, py;
            logic                okx, oky;
            res_t                r;
            ax0 = $signed(d[31:0]);
            ay0 = $signed(d[63:32]);
            ax1 = $signed(d[95:64]);
            ay1 = $signed(d[127:96]);
            bx0 = $signed(d[191:160]);
            by0 = $signed(d[223:192]);
            bx1 = $signed(d[255:224]);
            by1 = $signed(d[287:256]);
            dax = ax1 - ax0;
            day = ay1 - ay0;
            dbx = bx1 - bx0;
            dby = by1 - by0;
            det = dax * dby - day * dbx;
            r = '0;
            r.kind = HIT_NONE;
            if (det == 0) begin
                // Degenerate: horizontal B, then vertical B, then zero-length A,
                // then the cross-multiplied collinearity test.
                if (dby == 0) begin
                    r.kind = (by0 == ay0) ? HIT_COLLINEAR : HIT_NONE;
                end else if (dbx == 0) begin
                    r.kind = (bx0 == ax0) ? HIT_COLLINEAR : HIT_NONE;
                end else if (dax == 0 && day == 0) begin
                    r.kind = HIT_NONE;
                end else begin
                    lhs = (ax0 - bx0) * day;
                    rhs = (ay0 - by0) * dax;
                    r.kind = (lhs == rhs) ? HIT_COLLINEAR : HIT_NONE;
                end
            end else begin
                num = (bx0 - ax0) * dby - (by0 - ay0) * dbx;
                xn  = ax0 * det + dax * num;
                yn  = ay0 * det + day * num;
                if (det < 0) begin
                    det = -det;
                    xn  = -xn;
                    yn  = -yn;
                end
                round_to_grid(xn, det, px, okx);
                round_to_grid(yn, det, py, oky);
                if (okx && oky &&
                    px >= ((ax0 < ax1) ? ax0 : ax1) && px <= ((ax0 < ax1) ? ax1 : ax0) &&
                    py >= ((ay0 < ay1) ? ay0 : ay1) && py <= ((ay0 < ay1) ? ay1 : ay0)) begin
                    r.kind = HIT_POINT;
                    r.x    = px[31:0];
                    r.y    = py[31:0];
                    r.z    = d[159:128];
                end
            end
            return r;
        endfunction

        // Round n/den to nearest, ties away from zero; flag int32 overflow.
        function automatic void round_to_grid(input logic signed [127:0] n,
                                              input logic signed [127:0] den,
                                              output logic signed [127:0] q,
                                              output logic ok);
            logic                neg;
            logic signed [127:0] mag, rem;
            neg = (n < 0);
            mag = neg ? -n : n;
            q   = mag / den;
            rem = mag % den;
            if (2 * rem >= den) q = q + 1;
            ok = neg ? (q <= 128'sd2147483648) : (q <= 128'sd2147483647);
            if (neg) q = -q;
        endfunction

        function void note_input(logic [287:0] d);
            expect_q = {expect_q, predict(d)};
        endfunction

        function void check_result(logic [103:0] d);
            res_t want, got;
            got.kind = kind_t'(d[1:0]);
            got.x    = d[33:2];
            got.y    = d[65:34];
            got.z    = d[97:66];
            if (expect_q.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, actual %h", $time, d);
                return;
            end
            want = expect_q.pop_front();
            if (got.kind != want.kind) begin
                errors++;
                $display("%0t: hit_kind expected %0d actual %0d", $time, want.kind, got.kind);
            end
            if (got.x != want.x) begin
                errors++;
                $display("%0t: cross_x expected %0d actual %0d", $time, want.x, got.x);
            end
            if (got.y != want.y) begin
                errors++;
                $display("%0t: cross_y expected %0d actual %0d", $time, want.y, got.y);
            end
            if (got.z != want.z) begin
                errors++;
                $display("%0t: cross_z expected %0d actual %0d", $time, want.z, got.z);
            end
            if (d[103:98] != '0) begin
                errors++;
                $display("%0t: pad expected 0 actual %h", $time, d[103:98]);
            end
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [287:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;

    intersect_scoreboard sb = new();
    bit quiet = 1'b0;
    int idle_cycles = 0;
    int stall_left = 0;

    always #5 aclk = ~aclk;

    segment_line_intersect_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Record every transfer on both channels; feed the watchdog.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_input(s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Receiver: stall in random bursts, never once the quiet stretch starts.
    always @(posedge aclk) begin
        if (!aresetn || quiet) begin
            m_tready <= aresetn;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= (stall_left == 1);
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 6);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [287:0] pack_pair(int ax0, int ay0, int ax1, int ay1, int h,
                                               int bx0, int by0, int bx1, int by1);
        return {by1, bx1, by0, bx0, h, ay1, ax1, ay0, ax0};
    endfunction

    function automatic int rnd_near(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Present one pair, optionally after an idle burst, and hold it until taken.
    task automatic send_pair(logic [287:0] d);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Build one random pair, shaped so that hits and degenerate cases are common.
    task automatic send_random_pair();
        int ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, h, dx, dy, k, m;
        h = int'($urandom());
        case ($urandom_range(0, 9))
            0, 1: begin
                ax0 = $urandom(); ay0 = $urandom(); ax1 = $urandom(); ay1 = $urandom();
                bx0 = $urandom(); by0 = $urandom(); bx1 = $urandom(); by1 = $urandom();
            end
            2, 3, 4, 5: begin
                k = (1 << $urandom_range(2, 24));
                ax0 = rnd_near(k); ay0 = rnd_near(k); ax1 = rnd_near(k); ay1 = rnd_near(k);
                bx0 = rnd_near(k); by0 = rnd_near(k); bx1 = rnd_near(k); by1 = rnd_near(k);
            end
            6, 7: begin
                // Line B through a point near segment A, random direction.
                k = (1 << $urandom_range(4, 28));
                ax0 = rnd_near(k); ay0 = rnd_near(k); ax1 = rnd_near(k); ay1 = rnd_near(k);
                bx0 = ax0 / 2 + ax1 / 2 + rnd_near(3);
                by0 = ay0 / 2 + ay1 / 2 + rnd_near(3);
                bx1 = bx0 + rnd_near(k / 4);
                by1 = by0 + rnd_near(k / 4);
            end
            8: begin
                // Axis-aligned pairs and a zero-length A.
                k = 1 << 20;
                ax0 = rnd_near(k); ay0 = rnd_near(k); bx0 = rnd_near(k); by0 = rnd_near(k);
                case ($urandom_range(0, 2))
                    0: begin
                        ax1 = rnd_near(k); ay1 = ay0; bx1 = rnd_near(k); by1 = by0;
                        if ($urandom_range(0, 1)) by0 = ay0 + $urandom_range(0, 1);
                        by1 = by0;
                    end
                    1: begin
                        ax1 = ax0; ay1 = rnd_near(k); by1 = rnd_near(k);
                        bx0 = ax0 + $urandom_range(0, 1);
                        bx1 = bx0;
                    end
                    default: begin
                        ax1 = ax0; ay1 = ay0;
                        bx1 = bx0 + 1 + $urandom_range(0, 100);
                        by1 = by0 + 1 + $urandom_range(0, 100);
                    end
                endcase
            end
            default: begin
                // Parallel or collinear in a general direction.
                dx = rnd_near(1000); dy = rnd_near(1000);
                if (dx == 0) dx = 7;
                if (dy == 0) dy = -3;
                k = rnd_near(50); m = rnd_near(50);
                if (m == 0) m = 1;
                ax0 = rnd_near(1 << 24); ay0 = rnd_near(1 << 24);
                ax1 = ax0 + dx * rnd_near(40); ay1 = ay0 + dy * (ax1 - ax0) / dx;
                ax1 = ax0 + dx * 3; ay1 = ay0 + dy * 3;
                bx0 = ax0 + k * dx + ($urandom_range(0, 1) ? 0 : 1);
                by0 = ay0 + k * dy;
                bx1 = bx0 + m * dx; by1 = by0 + m * dy;
            end
        endcase
        send_pair(pack_pair(ax0, ay0, ax1, ay1, h, bx0, by0, bx1, by1));
    endtask

    initial begin
        int i;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Crossing inside A, crossing outside A, and extremes of every field.
        send_pair(pack_pair(0, 0, 65536, 65536, 123, 0, 65536, 65536, 0));
        send_pair(pack_pair(0, 0, 65536, 65536, -5, 200000, 0, 200000, 1));
        send_pair(pack_pair(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                            32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                            32'h7fff_ffff, 32'h8000_0000));
        send_pair(pack_pair(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                            32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                            32'h7fff_ffff, 32'h7fff_ffff));
        send_pair(pack_pair(-1, -1, -1, -1, -1, -1, -1, -1, -1));
        send_pair(pack_pair(0, 0, 0, 0, 0, 0, 0, 0, 0));
        // Horizontal B: collinear and parallel.
        send_pair(pack_pair(0, 5, 100, 5, 9, -3, 5, 40, 5));
        send_pair(pack_pair(0, 5, 100, 5, 9, -3, 6, 40, 6));
        // Zero-length B counts as horizontal.
        send_pair(pack_pair(0, 5, 100, 5, 9, 7, 5, 7, 5));
        // Vertical B: collinear and parallel.
        send_pair(pack_pair(8, 0, 8, 100, 1, 8, -9, 8, 30));
        send_pair(pack_pair(8, 0, 8, 100, 1, 9, -9, 9, 30));
        // Zero-length A against a sloped line.
        send_pair(pack_pair(4, 4, 4, 4, 1, 0, 0, 8, 8));
        // General direction: collinear and parallel.
        send_pair(pack_pair(0, 0, 30, 20, 1, 60, 40, 90, 60));
        send_pair(pack_pair(0, 0, 30, 20, 1, 61, 40, 91, 60));
        // Rounding ties in both signs, and a hit exactly on an endpoint.
        send_pair(pack_pair(0, 0, 4, 0, 2, 1, 1, 2, -1));
        send_pair(pack_pair(0, 0, -4, 0, 2, -1, 1, -2, -1));
        send_pair(pack_pair(0, 0, 10, 10, 3, 10, 0, 10, 50));
        // Points far outside A, at the edge of the int32 range.
        send_pair(pack_pair(32'h7fff_0000, 0, 32'h7fff_ffff, 1, 4,
                            32'h8000_0000, 0, 32'h8000_0000, 1));
        send_pair(pack_pair(0, 0, 1, 1, 4, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_fffe,
                            32'h8000_0000));

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            send_random_pair();
        end
        s_tvalid <= 1'b0;

        while (sb.expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.expect_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
